/* sv/suks_pkg.sv */
// Package for the sorted unique key set: sizes, command and status codes,
// and the control bundle broadcast from the top level to every storage cell.
// No dependencies.
`default_nettype none

package suks_pkg;

  localparam int CAPACITY  = 256;
  localparam int KEY_WIDTH = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_EXTRACT  = 2'd1;
  localparam logic [1:0] CMD_CONTAINS = 2'd2;
  localparam logic [1:0] CMD_REMOVE   = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic                 ins_en;
    logic                 rem_en;
    logic [KEY_WIDTH-1:0] key;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* sv/suks_cell.sv */
// One storage cell of the sorted key chain: holds one key, compares it with
// the broadcast key and shifts toward either neighbor. Depends on suks_pkg.
`default_nettype none

module suks_cell (
  input  wire logic                           clk,
  input  wire suks_pkg::cell_ctl_t            ctl,
  input  wire logic                           occ,
  input  wire logic                           occ_up,
  input  wire logic                           ge_dn,
  input  wire logic [suks_pkg::KEY_WIDTH-1:0] key_dn,
  input  wire logic [suks_pkg::KEY_WIDTH-1:0] key_up,
  output logic      [suks_pkg::KEY_WIDTH-1:0] key_q,
  output logic                                ge,
  output logic                                eq,
  output logic      [suks_pkg::KEY_WIDTH-1:0] top_key
);

  logic [suks_pkg::KEY_WIDTH-1:0] key_r;
  logic [suks_pkg::KEY_WIDTH-1:0] key_nxt;

  assign ge      = !occ || (key_r >= ctl.key);
  assign eq      = occ && (key_r == ctl.key);
  assign top_key = (occ && !occ_up) ? key_r : '0;
  assign key_q   = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctl.ins_en && ge) begin
      key_nxt = ge_dn ? key_dn : ctl.key;
    end else if (ctl.rem_en && ge && occ) begin
      key_nxt = key_up;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

/* sv/sorted_unique_key_set_unit.sv */
// Top level of the sorted unique key set: request register, chain of
// suks_cell storage cells, key count and result register. Depends on suks_pkg.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_command, in_key
//   out_     output     out_valid / out_ready  out_status, out_key_out, out_count
//
// Each request is first registered, then executed in a step in which all cells
// compare the key in parallel and shift by one place. A new request is taken
// while the previous result still waits in the output register.
// The execute cycle waits while the output register holds an untaken result.
// Reset empties the set at once; cell contents above the count are don't-care.
`default_nettype none

module sorted_unique_key_set_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_key_out,
  output logic [8:0]       out_count
);

  localparam int N  = suks_pkg::CAPACITY;
  localparam int KW = suks_pkg::KEY_WIDTH;
  localparam int CW = suks_pkg::CNT_W;

  logic          busy_r;
  logic [1:0]    cmd_r;
  logic [KW-1:0] key_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  logic [1:0]    status_r;
  logic [1:0]    status_nxt;
  logic [KW-1:0] kout_r;
  logic [KW-1:0] kout_nxt;
  logic [CW-1:0] ocount_r;

  logic          exec;
  logic          hit;
  logic          full;
  logic [KW-1:0] max_key;
  logic [N-1:0]  occ;
  logic [N-1:0]  ge;
  logic [N-1:0]  eq;
  logic [KW-1:0] cell_key [N];
  logic [KW-1:0] top_key  [N];

  suks_pkg::cell_ctl_t ctl;

  assign in_ready    = !busy_r;
  assign exec        = busy_r && (!out_valid_r || out_ready);
  assign hit         = |eq;
  assign full        = (count_r >= CW'(N));
  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_key_out = 32'(kout_r);
  assign out_count   = 9'(ocount_r);

  assign ctl.key    = key_r;
  assign ctl.ins_en = exec && (cmd_r == suks_pkg::CMD_INSERT) && !hit && !full;
  assign ctl.rem_en = exec && (cmd_r == suks_pkg::CMD_REMOVE) && hit;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign occ[i] = (count_r > CW'(i));
    suks_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .occ     (occ[i]),
      .occ_up  ((i == N - 1) ? 1'b0 : occ[(i + 1) % N]),
      .ge_dn   ((i == 0) ? 1'b0 : ge[(i + N - 1) % N]),
      .key_dn  (cell_key[(i + N - 1) % N]),
      .key_up  (cell_key[(i + 1) % N]),
      .key_q   (cell_key[i]),
      .ge      (ge[i]),
      .eq      (eq[i]),
      .top_key (top_key[i])
    );
  end

  always_comb begin
    max_key = '0;
    for (int i = 0; i < N; i++) begin
      max_key = max_key | top_key[i];
    end
  end

  always_comb begin
    status_nxt = suks_pkg::ST_DONE;
    kout_nxt   = '0;
    count_nxt  = count_r;
    case (cmd_r)
      suks_pkg::CMD_INSERT: begin
        if (hit) begin
          status_nxt = suks_pkg::ST_PRESENT;
        end else if (full) begin
          status_nxt = suks_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      suks_pkg::CMD_EXTRACT: begin
        if (count_r == '0) begin
          status_nxt = suks_pkg::ST_ABSENT;
        end else begin
          count_nxt = count_r - CW'(1);
          kout_nxt  = max_key;
        end
      end
      suks_pkg::CMD_CONTAINS: begin
        status_nxt = hit ? suks_pkg::ST_PRESENT : suks_pkg::ST_ABSENT;
      end
      suks_pkg::CMD_REMOVE: begin
        if (hit) begin
          count_nxt = count_r - CW'(1);
        end else begin
          status_nxt = suks_pkg::ST_ABSENT;
        end
      end
      default: begin
        status_nxt = suks_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        busy_r <= 1'b1;
      end else if (exec) begin
        busy_r <= 1'b0;
      end
      if (exec) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_command;
      key_r <= KW'(in_key);
    end
    if (exec) begin
      status_r <= status_nxt;
      kout_r   <= kout_nxt;
      ocount_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(N))
    else $error("key count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == suks_pkg::ST_FULL)) |-> (ocount_r == CW'(N)))
    else $error("full status with store not full");

  a_insert_inc: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the count");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r))
    else $error("result without a request in progress");

  a_remove_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rem_en |-> (count_r != '0))
    else $error("remove from an empty store");
`endif

endmodule

`default_nettype wire

/* sim/key_set_checker.sv */
`timescale 1ns / 100ps
// Checker for the sorted unique key set: watches both request and result channels,
// keeps its own sorted copy of the key set and compares every result with its
// prediction. Depends on suks_pkg.
module key_set_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_key,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_key_out,
  input  logic [8:0]  out_count,
  output int          mismatch_count,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0]                 status;
    logic [31:0]                key_out;
    logic [suks_pkg::CNT_W-1:0] count;
  } set_result_t;

  logic [suks_pkg::KEY_WIDTH-1:0] held_keys [suks_pkg::CAPACITY];
  int                             held_count;
  set_result_t                    expected_results [$];

  function automatic set_result_t apply_command(input logic [1:0] cmd, input logic [31:0] key);
    set_result_t                    r;
    logic [suks_pkg::KEY_WIDTH-1:0] k;
    int                             pos;
    logic                           hit;
    logic                           stop;
    k = key[suks_pkg::KEY_WIDTH-1:0];
    r.status = suks_pkg::ST_DONE;
    r.key_out = '0;
    pos = 0;
    hit = 1'b0;
    stop = 1'b0;
    while (!stop && pos < held_count) begin
      if (held_keys[pos] == k) begin
        hit = 1'b1;
        stop = 1'b1;
      end else if (held_keys[pos] > k) begin
        stop = 1'b1;
      end else begin
        pos++;
      end
    end
    case (cmd)
      suks_pkg::CMD_INSERT: begin
        if (hit) begin
          r.status = suks_pkg::ST_PRESENT;
        end else if (held_count >= suks_pkg::CAPACITY) begin
          r.status = suks_pkg::ST_FULL;
        end else begin
          for (int i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
          held_keys[pos] = k;
          held_count++;
        end
      end
      suks_pkg::CMD_EXTRACT: begin
        if (held_count == 0) begin
          r.status = suks_pkg::ST_ABSENT;
        end else begin
          held_count--;
          r.key_out = 32'(held_keys[held_count]);
        end
      end
      suks_pkg::CMD_CONTAINS: begin
        r.status = hit ? suks_pkg::ST_PRESENT : suks_pkg::ST_ABSENT;
      end
      default: begin
        if (hit) begin
          for (int i = pos; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
          held_count--;
        end else begin
          r.status = suks_pkg::ST_ABSENT;
        end
      end
    endcase
    r.count = suks_pkg::CNT_W'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    set_result_t want;
    if (!rst_n) begin
      expected_results.delete();
      held_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            mismatch_count++;
          end
          if (out_key_out !== want.key_out) begin
            $error("out_key_out: expected %h, got %h", want.key_out, out_key_out);
            mismatch_count++;
          end
          if (out_count !== want.count) begin
            $error("out_count: expected %0d, got %0d", want.count, out_count);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_command(in_command, in_key));
    end
    outstanding <= expected_results.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Top of the sorted unique key set testbench: clock, reset, request stimulus and
// random output back-pressure, and the final verdict. Depends on suks_pkg,
// sorted_unique_key_set_unit and key_set_checker.
module tb;

  localparam int POOL_SIZE = 320;

  typedef enum {PH_FILL, PH_MIXED, PH_DRAIN} phase_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [31:0] in_key;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_key_out;
  logic [8:0]  out_count;

  int          mismatch_count;
  int          outstanding;
  int          idle_pct;
  int          stall_pct;
  int          pool_next;
  logic [31:0] key_pool [POOL_SIZE];

  sorted_unique_key_set_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_key_out (out_key_out),
    .out_count   (out_count)
  );

  key_set_checker set_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_key_out    (out_key_out),
    .out_count      (out_count),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("sorted_unique_key_set_unit test failed");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic [31:0] key);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_key <= key;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic wait_settled();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic run_phase(input phase_kind_t kind, input int n);
    int          roll;
    logic [1:0]  cmd;
    logic [31:0] key;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      key = pick_key();
      case (kind)
        PH_FILL: begin
          if (roll < 85) begin
            cmd = suks_pkg::CMD_INSERT;
            key = key_pool[pool_next % POOL_SIZE];
            pool_next++;
          end else begin
            cmd = 2'($urandom_range(3));
          end
        end
        PH_MIXED: cmd = 2'($urandom_range(3));
        default:  cmd = (roll < 75) ? suks_pkg::CMD_EXTRACT : suks_pkg::CMD_REMOVE;
      endcase
      send_request(cmd, key);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = suks_pkg::CMD_INSERT;
    in_key = '0;
    idle_pct = 0;
    stall_pct = 0;
    pool_next = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_request(suks_pkg::CMD_EXTRACT,  32'h0000_0000);
    send_request(suks_pkg::CMD_CONTAINS, 32'h0000_0000);
    send_request(suks_pkg::CMD_REMOVE,   32'h0000_0000);
    send_request(suks_pkg::CMD_INSERT,   32'h8000_0000);
    send_request(suks_pkg::CMD_INSERT,   32'h0000_0000);
    send_request(suks_pkg::CMD_INSERT,   32'hFFFF_FFFF);
    send_request(suks_pkg::CMD_INSERT,   32'h0000_0000);
    send_request(suks_pkg::CMD_CONTAINS, 32'hFFFF_FFFF);
    send_request(suks_pkg::CMD_CONTAINS, 32'h7FFF_FFFF);
    send_request(suks_pkg::CMD_INSERT,   32'h5555_5555);
    send_request(suks_pkg::CMD_INSERT,   32'hAAAA_AAAA);
    send_request(suks_pkg::CMD_REMOVE,   32'h8000_0000);
    send_request(suks_pkg::CMD_REMOVE,   32'h8000_0000);
    send_request(suks_pkg::CMD_REMOVE,   32'hFFFF_FFFF);
    send_request(suks_pkg::CMD_EXTRACT,  32'h0000_0000);
    send_request(suks_pkg::CMD_REMOVE,   32'h0000_0000);
    send_request(suks_pkg::CMD_EXTRACT,  32'h0000_0000);
    send_request(suks_pkg::CMD_EXTRACT,  32'h0000_0000);
    send_request(suks_pkg::CMD_INSERT,   32'h0000_0001);
    send_request(suks_pkg::CMD_EXTRACT,  32'hFFFF_FFFF);
    wait_settled();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 59; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      run_phase(PH_FILL, 190);
      wait_settled();
      run_phase(PH_MIXED, 70);
      run_phase(PH_DRAIN, 40);
      wait_settled();
    end

    // Empty the set completely so that extracts from an empty set recur.
    run_phase(PH_DRAIN, 360);
    wait_settled();
    repeat (10) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("sorted_unique_key_set_unit test passed");
    end else begin
      $display("sorted_unique_key_set_unit test failed");
    end
    $finish;
  end

endmodule
